@@ rtl/tcp_header_check_and_option_parse_defines.svh @@
// assertion macros for the checker file of the tcp header checker
`ifndef TCP_HEADER_CHECK_AND_OPTION_PARSE_DEFINES_SVH
`define TCP_HEADER_CHECK_AND_OPTION_PARSE_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define THCOP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("thcop check failed");

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define THCOP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("thcop check failed");

`endif

@@ rtl/thcop_pkg.sv @@
// types, constants and helpers of the tcp header checker
`timescale 1ns / 1ps

package thcop_pkg;

    localparam int DEF_MAX_CAPTURE_BYTES = 65535;

    // header byte positions
    localparam int HDR_BYTES     = 20;
    localparam int POS_SPORT_LO  = 1;
    localparam int POS_DPORT_LO  = 3;
    localparam int POS_ACK_FIRST = 8;
    localparam int POS_ACK_LAST  = 11;
    localparam int POS_OFFSET    = 12;
    localparam int POS_FLAGS     = 13;
    localparam int MIN_HDR_WORDS = 5;

    // flag bits
    localparam logic [7:0] FLAG_FIN   = 8'h01;
    localparam logic [7:0] FLAG_SYN   = 8'h02;
    localparam logic [7:0] FLAG_RST   = 8'h04;
    localparam logic [7:0] FLAG_ACK   = 8'h10;
    localparam logic [7:0] FLAG_MINOR = 8'hE8;

    // option kinds
    localparam logic [7:0] OPT_NOP  = 8'd1;
    localparam logic [7:0] OPT_MSS  = 8'd2;
    localparam logic [7:0] OPT_SACK = 8'd5;
    localparam logic [7:0] OPT_TS   = 8'd8;
    localparam logic [6:0] MSS_SPAN = 7'd4;

    // legal sack option sizes
    localparam logic [7:0] SACK_LEN_1 = 8'd10;
    localparam logic [7:0] SACK_LEN_2 = 8'd18;
    localparam logic [7:0] SACK_LEN_3 = 8'd26;
    localparam logic [7:0] SACK_LEN_4 = 8'd34;

    typedef enum logic [2:0] {
        CAUSE_NONE   = 3'd0,
        CAUSE_OFFSET = 3'd1,
        CAUSE_PORT   = 3'd2,
        CAUSE_ACK    = 3'd3,
        CAUSE_SYN    = 3'd4,
        CAUSE_FLAGS  = 3'd5,
        CAUSE_OPTLEN = 3'd6,
        CAUSE_SACK   = 3'd7
    } t_cause;

    // walk phase: waiting for a kind, for a size, or inside a body
    typedef enum logic [1:0] {
        CUR_KIND = 2'd0,
        CUR_SIZE = 2'd1,
        CUR_BODY = 2'd2
    } t_cursor;

    typedef struct packed {
        logic [7:0]  seg_byte;
        logic [15:0] seg_total_len;
        logic        last_byte;
    } t_seg_word;

    typedef struct packed {
        logic        header_short;
        logic        bogus;
        logic [2:0]  bogus_cause;
        logic        mss_seen;
        logic [15:0] mss_value;
        logic        timestamp_seen;
        logic [5:0]  unknown_option_bytes;
    } t_res_word;

    typedef struct packed {
        logic [6:0]  walk_used;
        t_cursor     cursor;
        logic        kind_sack;
        t_cause      fault;
        logic [2:0]  mss_pending;
        logic        mss_seen;
        logic [15:0] mss_hold;
        logic        ts_seen;
    } t_walk;

    localparam t_walk WALK_CLEAR = '{
        walk_used:   7'd0,
        cursor:      CUR_KIND,
        kind_sack:   1'b0,
        fault:       CAUSE_NONE,
        mss_pending: 3'd0,
        mss_seen:    1'b0,
        mss_hold:    16'd0,
        ts_seen:     1'b0
    };

    // segment state frozen on the last byte
    typedef struct packed {
        logic        cap_short;
        logic        cap_opt_lt2;
        logic        sack_over;
        logic [15:0] held_len;
        logic [1:0]  port_bits;
        logic        ack_nz;
        logic [3:0]  hdr_words;
        logic [7:0]  flags;
        t_walk       walk;
    } t_snap;

    // option bytes implied by the data offset
    function automatic logic [5:0] opt_len_of(input logic [3:0] hdr_words);
        logic [5:0] res;
        if (hdr_words >= 4'(MIN_HDR_WORDS)) begin
            res = {hdr_words, 2'b00} - 6'(HDR_BYTES);
        end else begin
            res = 6'd0;
        end
        return res;
    endfunction

endpackage

@@ rtl/thcop_stream_if.sv @@
// valid/ready channel carrying one word of a given type
`timescale 1ns / 1ps

interface thcop_stream_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/thcop_opt_walk.sv @@
// tcp option walker: one option byte per cycle while i_en is high, tracks mss, timestamp and faults
`timescale 1ns / 1ps

module thcop_opt_walk (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_clr,
    input  logic [5:0]        i_pos,
    input  logic [7:0]        i_byte,
    input  logic [7:0]        i_prev_byte,
    input  logic [5:0]        i_opt_len,
    output thcop_pkg::t_walk  o_walk_next
);

    thcop_pkg::t_walk   r_walk;
    thcop_pkg::t_walk   n_walk;
    thcop_pkg::t_cursor n_cursor;

    logic       kind_hit;
    logic       size_hit;
    logic       sack_bad;
    logic       size_bad;
    logic [8:0] size_sum;
    logic [6:0] pos_w;
    logic [7:0] opt_len_b;

    assign pos_w     = {1'b0, i_pos};
    assign opt_len_b = {2'b00, i_opt_len};
    assign size_sum  = {2'b00, r_walk.walk_used} + {1'b0, i_byte};

    assign kind_hit = i_en && (r_walk.fault == thcop_pkg::CAUSE_NONE)
                   && (r_walk.cursor != thcop_pkg::CUR_SIZE) && (pos_w == r_walk.walk_used);
    assign size_hit = i_en && (r_walk.fault == thcop_pkg::CAUSE_NONE)
                   && (r_walk.cursor == thcop_pkg::CUR_SIZE)
                   && (pos_w == r_walk.walk_used + 7'd1);

    always_comb begin
        sack_bad = 1'b0;
        if (r_walk.kind_sack) begin
            sack_bad = !(i_byte inside {thcop_pkg::SACK_LEN_1, thcop_pkg::SACK_LEN_2,
                                        thcop_pkg::SACK_LEN_3, thcop_pkg::SACK_LEN_4})
                    || (size_sum > {1'b0, opt_len_b});
        end
        size_bad = (i_byte == 8'd0) || (i_byte > opt_len_b);
    end

    // walk phase
    always_comb begin
        n_cursor = r_walk.cursor;
        if (kind_hit) begin
            n_cursor = (i_byte == thcop_pkg::OPT_NOP) ? thcop_pkg::CUR_KIND
                                                      : thcop_pkg::CUR_SIZE;
        end else if (size_hit && !sack_bad && !size_bad) begin
            n_cursor = thcop_pkg::CUR_BODY;
        end
    end

    // option findings
    always_comb begin
        n_walk = r_walk;
        if (i_en) begin
            if (r_walk.mss_pending[0]) begin
                n_walk.mss_hold = {i_prev_byte, i_byte};
                n_walk.mss_seen = 1'b1;
            end
            n_walk.mss_pending = r_walk.mss_pending >> 1;
        end
        if (kind_hit) begin
            n_walk.kind_sack = (i_byte == thcop_pkg::OPT_SACK);
            if ((i_byte == thcop_pkg::OPT_MSS)
                && (r_walk.walk_used + thcop_pkg::MSS_SPAN <= {1'b0, i_opt_len})) begin
                n_walk.mss_pending[2] = 1'b1;
            end
            if (i_byte == thcop_pkg::OPT_TS) begin
                n_walk.ts_seen = 1'b1;
            end
            if (i_byte == thcop_pkg::OPT_NOP) begin
                n_walk.walk_used = pos_w + 7'd1;
            end
        end else if (size_hit) begin
            if (sack_bad) begin
                n_walk.fault = thcop_pkg::CAUSE_SACK;
            end else if (size_bad) begin
                n_walk.fault = thcop_pkg::CAUSE_OPTLEN;
            end else begin
                n_walk.walk_used = size_sum[6:0];
            end
        end
        n_walk.cursor = n_cursor;
    end

    assign o_walk_next = n_walk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_walk <= thcop_pkg::WALK_CLEAR;
        end else begin
            r_walk <= n_walk;
        end
    end

endmodule

@@ rtl/thcop_verdict.sv @@
// header checks and final option verdict from the frozen segment state
`timescale 1ns / 1ps

module thcop_verdict (
    input  thcop_pkg::t_snap     i_snap,
    output thcop_pkg::t_res_word o_res
);

    logic [5:0]        doff;
    logic [5:0]        opt_len;
    logic [7:0]        core_flags;
    thcop_pkg::t_cause hdr_cause;
    thcop_pkg::t_cause walk_cause;

    assign doff       = {i_snap.hdr_words, 2'b00};
    assign opt_len    = thcop_pkg::opt_len_of(i_snap.hdr_words);
    assign core_flags = i_snap.flags & ~thcop_pkg::FLAG_MINOR;

    always_comb begin
        hdr_cause = thcop_pkg::CAUSE_NONE;
        if ((doff < 6'(thcop_pkg::HDR_BYTES)) || (16'(doff) > i_snap.held_len)) begin
            hdr_cause = thcop_pkg::CAUSE_OFFSET;
        end else if (i_snap.port_bits != 2'b11) begin
            hdr_cause = thcop_pkg::CAUSE_PORT;
        end else if (((i_snap.flags & thcop_pkg::FLAG_ACK) != 8'd0) && !i_snap.ack_nz) begin
            hdr_cause = thcop_pkg::CAUSE_ACK;
        end else if ((i_snap.flags == thcop_pkg::FLAG_SYN)
                     && (i_snap.held_len > 16'(doff))) begin
            hdr_cause = thcop_pkg::CAUSE_SYN;
        end else if (!(core_flags inside {
                         thcop_pkg::FLAG_ACK,
                         thcop_pkg::FLAG_SYN,
                         thcop_pkg::FLAG_SYN | thcop_pkg::FLAG_ACK,
                         thcop_pkg::FLAG_FIN | thcop_pkg::FLAG_ACK,
                         thcop_pkg::FLAG_FIN,
                         thcop_pkg::FLAG_RST,
                         thcop_pkg::FLAG_RST | thcop_pkg::FLAG_ACK})) begin
            hdr_cause = thcop_pkg::CAUSE_FLAGS;
        end
    end

    // sack left open at the end of the capture counts as a sack fault
    always_comb begin
        walk_cause = i_snap.walk.fault;
        if ((walk_cause == thcop_pkg::CAUSE_NONE) && i_snap.walk.kind_sack
            && ((i_snap.walk.cursor == thcop_pkg::CUR_SIZE)
                || ((i_snap.walk.cursor == thcop_pkg::CUR_BODY) && i_snap.sack_over))) begin
            walk_cause = thcop_pkg::CAUSE_SACK;
        end
    end

    always_comb begin
        o_res = '0;
        if (i_snap.cap_short) begin
            o_res.header_short = 1'b1;
        end else if (hdr_cause != thcop_pkg::CAUSE_NONE) begin
            o_res.bogus       = 1'b1;
            o_res.bogus_cause = hdr_cause;
        end else if ((opt_len == 6'd0) || i_snap.cap_opt_lt2) begin
            o_res.unknown_option_bytes = opt_len;
        end else begin
            if (walk_cause != thcop_pkg::CAUSE_NONE) begin
                o_res.bogus       = 1'b1;
                o_res.bogus_cause = walk_cause;
            end else if (i_snap.walk.walk_used < {1'b0, opt_len}) begin
                o_res.unknown_option_bytes = opt_len - i_snap.walk.walk_used[5:0];
            end
            if (i_snap.walk.mss_seen) begin
                o_res.mss_seen  = 1'b1;
                o_res.mss_value = i_snap.walk.mss_hold;
            end
            o_res.timestamp_seen = i_snap.walk.ts_seen;
        end
    end

endmodule

@@ rtl/tcp_header_check_and_option_parse.sv @@
// top level of the tcp header checker and option parser
`timescale 1ns / 1ps

// tcp header checker and option parser. takes one captured segment byte per
// word on i_seg, header first, and returns one verdict word on o_res for the
// word marked last_byte; other words give no result. a new byte is taken
// every clock while i_seg.ready is high: each byte only updates a byte
// counter, a few header fields and the option walker. the verdict passes
// from the frozen state register to the result register: the edge that takes
// the last byte freezes the segment state, and the result register loads it
// once free. the frozen state has its own register, so the next segment
// streams in while a verdict waits on o_res; input stalls only when both the
// frozen slot and the result register are full and the result is not taken.
// bytes past MAX_CAPTURE_BYTES are ignored except for their last_byte mark.
module tcp_header_check_and_option_parse #(
    parameter int MAX_CAPTURE_BYTES = thcop_pkg::DEF_MAX_CAPTURE_BYTES
) (
    input logic           i_clk,
    input logic           i_rst_n,
    thcop_stream_if.sink  i_seg,
    thcop_stream_if.source o_res
);

    localparam int CNT_W = $clog2(MAX_CAPTURE_BYTES + 1);
    // wide enough for byte positions, option lengths and walk offsets
    localparam int CMP_W = (CNT_W + 1 > 8) ? CNT_W + 1 : 8;

    // per-segment header state
    logic [CNT_W-1:0] r_byte_count, n_byte_count;
    logic [15:0]      r_held_len, n_held_len;
    logic [1:0]       r_port_bits, n_port_bits;
    logic             r_ack_nz, n_ack_nz;
    logic [3:0]       r_hdr_words, n_hdr_words;
    logic [7:0]       r_flags, n_flags;
    logic [7:0]       r_prev_byte, n_prev_byte;

    // frozen segment and result stages
    logic                 r_s1_valid;
    thcop_pkg::t_snap     r_snap, n_snap;
    logic                 r_out_valid;
    thcop_pkg::t_res_word r_res;
    thcop_pkg::t_res_word verdict;

    logic             seg_acc;
    logic             seg_last_acc;
    logic             out_free;
    logic             counted;
    logic             opt_en;
    logic [5:0]       opt_len;
    logic [CMP_W-1:0] idx_w;
    logic [CMP_W-1:0] opt_pos;
    logic [CMP_W-1:0] cap_w;
    logic [CMP_W-1:0] cap_opt;
    logic [7:0]       seg_byte;
    thcop_pkg::t_walk walk_next;

    // handshake: result register frees when taken, frozen slot when it moves on
    assign out_free     = !r_out_valid || o_res.ready;
    assign i_seg.ready  = !r_s1_valid || out_free;
    assign seg_acc      = i_seg.valid && i_seg.ready;
    assign seg_last_acc = seg_acc && i_seg.data.last_byte;
    assign o_res.valid  = r_out_valid;
    assign o_res.data   = r_res;

    assign seg_byte = i_seg.data.seg_byte;
    assign counted  = r_byte_count < CNT_W'(MAX_CAPTURE_BYTES);
    assign opt_len  = thcop_pkg::opt_len_of(r_hdr_words);
    assign idx_w    = CMP_W'(r_byte_count);
    assign opt_pos  = idx_w - CMP_W'(thcop_pkg::HDR_BYTES);

    // header field capture by byte position
    always_comb begin
        n_byte_count = r_byte_count;
        n_held_len   = r_held_len;
        n_port_bits  = r_port_bits;
        n_ack_nz     = r_ack_nz;
        n_hdr_words  = r_hdr_words;
        n_flags      = r_flags;
        n_prev_byte  = r_prev_byte;
        opt_en       = 1'b0;
        if (seg_acc) begin
            if (r_byte_count == '0) begin
                n_held_len = i_seg.data.seg_total_len;
            end
            if (counted) begin
                if (idx_w <= CMP_W'(thcop_pkg::POS_SPORT_LO)) begin
                    if (seg_byte != 8'd0) begin
                        n_port_bits[0] = 1'b1;
                    end
                end else if (idx_w <= CMP_W'(thcop_pkg::POS_DPORT_LO)) begin
                    if (seg_byte != 8'd0) begin
                        n_port_bits[1] = 1'b1;
                    end
                end else if ((idx_w >= CMP_W'(thcop_pkg::POS_ACK_FIRST))
                             && (idx_w <= CMP_W'(thcop_pkg::POS_ACK_LAST))) begin
                    if (seg_byte != 8'd0) begin
                        n_ack_nz = 1'b1;
                    end
                end else if (idx_w == CMP_W'(thcop_pkg::POS_OFFSET)) begin
                    n_hdr_words = seg_byte[7:4];
                end else if (idx_w == CMP_W'(thcop_pkg::POS_FLAGS)) begin
                    n_flags = seg_byte;
                end else if (idx_w >= CMP_W'(thcop_pkg::HDR_BYTES)) begin
                    // only bytes inside the options reach the walker
                    opt_en = opt_pos < CMP_W'(opt_len);
                end
                n_prev_byte  = seg_byte;
                n_byte_count = r_byte_count + CNT_W'(1);
            end
        end
    end

    thcop_opt_walk u_opt_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (opt_en),
        .i_clr       (seg_last_acc),
        .i_pos       (opt_pos[5:0]),
        .i_byte      (seg_byte),
        .i_prev_byte (r_prev_byte),
        .i_opt_len   (opt_len),
        .o_walk_next (walk_next)
    );

    // capture length tests are settled here so the verdict stage stays narrow
    assign cap_w   = CMP_W'(n_byte_count);
    assign cap_opt = cap_w - CMP_W'(thcop_pkg::HDR_BYTES);

    always_comb begin
        n_snap.cap_short   = cap_w < CMP_W'(thcop_pkg::HDR_BYTES);
        n_snap.cap_opt_lt2 = cap_opt < CMP_W'(2);
        n_snap.sack_over   = CMP_W'(walk_next.walk_used) > cap_opt;
        n_snap.held_len    = n_held_len;
        n_snap.port_bits   = n_port_bits;
        n_snap.ack_nz      = n_ack_nz;
        n_snap.hdr_words   = n_hdr_words;
        n_snap.flags       = n_flags;
        n_snap.walk        = walk_next;
    end

    thcop_verdict u_verdict (
        .i_snap (r_snap),
        .o_res  (verdict)
    );

    // segment state, cleared after each last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || seg_last_acc) begin
            r_byte_count <= '0;
            r_held_len   <= 16'd0;
            r_port_bits  <= 2'b00;
            r_ack_nz     <= 1'b0;
            r_hdr_words  <= 4'd0;
            r_flags      <= 8'd0;
            r_prev_byte  <= 8'd0;
        end else begin
            r_byte_count <= n_byte_count;
            r_held_len   <= n_held_len;
            r_port_bits  <= n_port_bits;
            r_ack_nz     <= n_ack_nz;
            r_hdr_words  <= n_hdr_words;
            r_flags      <= n_flags;
            r_prev_byte  <= n_prev_byte;
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (seg_last_acc) begin
                r_s1_valid <= 1'b1;
            end else if (out_free) begin
                r_s1_valid <= 1'b0;
            end
            if (r_s1_valid && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (seg_last_acc) begin
            r_snap <= n_snap;
        end
        if (r_s1_valid && out_free) begin
            r_res <= verdict;
        end
    end

endmodule

@@ rtl/thcop_checker.sv @@
// port-level checks of the tcp header checker, bound to the top level
`timescale 1ns / 1ps
`include "tcp_header_check_and_option_parse_defines.svh"

module thcop_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_seg_ready,
    input logic                 i_res_valid,
    input logic                 i_res_ready,
    input thcop_pkg::t_res_word i_res_data
);

    // a held verdict word keeps its value
    `THCOP_ASSERT_NEXT(a_res_hold, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_data))

    // input only backs up when a verdict sits untaken
    `THCOP_ASSERT_IMP(a_in_stall_cause, !i_seg_ready, i_res_valid && !i_res_ready)

    // short capture reports nothing else
    `THCOP_ASSERT_IMP(a_short_clean, i_res_valid && i_res_data.header_short, !i_res_data.bogus && (i_res_data.bogus_cause == 3'd0) && !i_res_data.mss_seen && (i_res_data.mss_value == 16'd0) && !i_res_data.timestamp_seen && (i_res_data.unknown_option_bytes == 6'd0))

    // fault flag agrees with its cause, and a fault leaves no unwalked count
    `THCOP_ASSERT_IMP(a_bogus_cause, i_res_valid, (i_res_data.bogus == (i_res_data.bogus_cause != 3'd0)) && (!i_res_data.bogus || (i_res_data.unknown_option_bytes == 6'd0)))

    // mss value only with mss seen, option count within forty
    `THCOP_ASSERT_IMP(a_mss_range, i_res_valid, (i_res_data.mss_seen || (i_res_data.mss_value == 16'd0)) && (i_res_data.unknown_option_bytes <= 6'd40))

endmodule

bind tcp_header_check_and_option_parse thcop_checker u_thcop_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_seg_ready (i_seg.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.data)
);
